// ===== sv/linear_probe_hash_table_defines.svh =====
// Assertion macros for the linear probe hash table.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define LPHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lpht: same-cycle check failed");
`define LPHT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lpht: next-cycle check failed");
`else
`define LPHT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LPHT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/lpht_pkg.sv =====
// Shared types and codes for the linear probe hash table.
`default_nettype none
package lpht_pkg;
    typedef logic [1:0] t_mark;
    localparam t_mark MARK_EMPTY   = 2'd0;
    localparam t_mark MARK_USED    = 2'd1;
    localparam t_mark MARK_DELETED = 2'd2;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_INSERT = 2'd0;
    localparam t_kind KIND_REMOVE = 2'd1;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_SAME    = 3'd1;
    localparam t_status ST_OTHER   = 3'd2;
    localparam t_status ST_MISSING = 3'd3;
    localparam t_status ST_FULL    = 3'd4;

    localparam int FVAL_W  = 32;
    localparam int COUNT_W = 7;

    typedef struct packed {
        logic  rd_en;
        logic  mark_we;
        logic  kv_we;
        t_mark wr_mark;
    } t_mem_ctl;
endpackage
`default_nettype wire

// ===== sv/lpht_store.sv =====
// Slot storage: mark memory and key/value memory, registered reads.
`default_nettype none
module lpht_store #(
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    localparam int IDX_W     = $clog2(CAPACITY)
) (
    input  wire logic                  i_clk,
    input  wire lpht_pkg::t_mem_ctl    i_ctl,
    input  wire logic [IDX_W-1:0]      i_rd_addr,
    input  wire logic [IDX_W-1:0]      i_wr_addr,
    input  wire logic [KEY_BITS-1:0]   i_wr_key,
    input  wire logic [VALUE_BITS-1:0] i_wr_val,
    output lpht_pkg::t_mark            o_rd_mark,
    output logic      [KEY_BITS-1:0]   o_rd_key,
    output logic      [VALUE_BITS-1:0] o_rd_val
);
    import lpht_pkg::*;

    t_mark                          r_marks [CAPACITY];
    logic [KEY_BITS+VALUE_BITS-1:0] r_kv    [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_ctl.mark_we) begin
            r_marks[i_wr_addr] <= i_ctl.wr_mark;
        end
        if (i_ctl.kv_we) begin
            r_kv[i_wr_addr] <= {i_wr_key, i_wr_val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_mark              <= r_marks[i_rd_addr];
            {o_rd_key, o_rd_val}   <= r_kv[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/lpht_ctrl.sv =====
// Sequencer: clearing sweep, serial key hash, pipelined probe walk and update.
`default_nettype none
module lpht_ctrl #(
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    localparam int IDX_W     = $clog2(CAPACITY),
    localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire lpht_pkg::t_kind       i_kind,
    input  wire logic [KEY_BITS-1:0]   i_key,
    input  wire logic [VALUE_BITS-1:0] i_value,
    output lpht_pkg::t_mem_ctl         o_mem_ctl,
    output logic      [IDX_W-1:0]      o_rd_addr,
    output logic      [IDX_W-1:0]      o_wr_addr,
    output logic      [KEY_BITS-1:0]   o_wr_key,
    output logic      [VALUE_BITS-1:0] o_wr_val,
    input  wire lpht_pkg::t_mark       i_rd_mark,
    input  wire logic [KEY_BITS-1:0]   i_rd_key,
    input  wire logic [VALUE_BITS-1:0] i_rd_val,
    output logic                       o_res_valid,
    input  wire logic                  i_res_ready,
    output lpht_pkg::t_status          o_res_status,
    output logic      [VALUE_BITS-1:0] o_res_fval,
    output logic      [CNT_W-1:0]      o_res_count
);
    import lpht_pkg::*;

    localparam int KPAD   = ((KEY_BITS + 3) / 4) * 4;
    localparam int NSTEP  = KPAD / 4;
    localparam int STEP_W = $clog2(NSTEP);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEP - 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(CAPACITY - 1);
    localparam logic [IDX_W:0]    CAP_EXT   = (IDX_W + 1)'(CAPACITY);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]            r_state;
    logic [IDX_W-1:0]      r_addr;
    logic [IDX_W-1:0]      r_eval_idx;
    logic                  r_pend;
    logic [IDX_W-1:0]      r_seen;
    logic                  r_free_vld;
    logic [IDX_W-1:0]      r_free;
    logic [CNT_W-1:0]      r_count;
    t_kind                 r_kind;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [KPAD-1:0]       r_sh;
    logic [STEP_W-1:0]     r_step;
    logic [IDX_W-1:0]      r_rem;
    t_status               r_status;
    logic [VALUE_BITS-1:0] r_fval;

    logic [IDX_W-1:0]      h_rem;
    logic [IDX_W-1:0]      addr_nxt;
    logic                  e_hit;
    logic                  e_stop;
    logic                  e_free_vld;
    logic [IDX_W-1:0]      e_free;
    t_status               f_status;
    logic [VALUE_BITS-1:0] f_fval;
    logic [CNT_W-1:0]      f_count;

    // four remainder steps per cycle, most significant key bit first
    always_comb begin
        logic [IDX_W:0] acc;
        h_rem = r_rem;
        for (int j = 0; j < 4; j++) begin
            acc = {h_rem, r_sh[KPAD-1-j]};
            if (acc >= CAP_EXT) begin
                acc = acc - CAP_EXT;
            end
            h_rem = acc[IDX_W-1:0];
        end
    end

    assign addr_nxt = (r_addr == LAST_IDX) ? '0 : r_addr + 1'b1;

    always_comb begin
        e_hit      = 1'b0;
        e_stop     = 1'b0;
        e_free_vld = r_free_vld;
        e_free     = r_free;
        if (r_pend) begin
            if (i_rd_mark == MARK_EMPTY) begin
                if (!r_free_vld) begin
                    e_free_vld = 1'b1;
                    e_free     = r_eval_idx;
                end
                e_stop = 1'b1;
            end else if (i_rd_mark == MARK_USED && i_rd_key == r_key) begin
                e_hit  = 1'b1;
                e_stop = 1'b1;
            end else if (i_rd_mark == MARK_DELETED && !r_free_vld) begin
                e_free_vld = 1'b1;
                e_free     = r_eval_idx;
            end
            if (r_seen == LAST_IDX) begin
                e_stop = 1'b1;
            end
        end
    end

    always_comb begin
        o_mem_ctl  = '0;
        o_rd_addr  = r_addr;
        o_wr_addr  = r_eval_idx;
        o_wr_key   = r_key;
        o_wr_val   = r_val;
        f_status   = ST_MISSING;
        f_fval     = '0;
        f_count    = r_count;
        if (r_state == S_CLEAR) begin
            o_mem_ctl.mark_we = 1'b1;
            o_mem_ctl.wr_mark = MARK_EMPTY;
            o_wr_addr         = r_addr;
        end
        if (r_state == S_PROBE) begin
            o_mem_ctl.rd_en = 1'b1;
            unique case (r_kind)
                KIND_INSERT: begin
                    o_wr_addr = e_free;
                    if (e_hit) begin
                        f_fval   = i_rd_val;
                        f_status = (i_rd_val == r_val) ? ST_SAME : ST_OTHER;
                    end else if (!e_free_vld) begin
                        f_status = ST_FULL;
                    end else begin
                        o_mem_ctl.mark_we = e_stop;
                        o_mem_ctl.kv_we   = e_stop;
                        o_mem_ctl.wr_mark = MARK_USED;
                        f_count           = r_count + 1'b1;
                        f_status          = ST_OK;
                        f_fval            = r_val;
                    end
                end
                KIND_REMOVE: begin
                    if (e_hit) begin
                        o_mem_ctl.mark_we = e_stop;
                        o_mem_ctl.wr_mark = MARK_DELETED;
                        f_fval            = i_rd_val;
                        f_status          = ST_OK;
                        if (r_count != '0) begin
                            f_count = r_count - 1'b1;
                        end
                    end
                end
                default: begin
                    if (e_hit) begin
                        f_fval   = i_rd_val;
                        f_status = ST_OK;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_pend  <= 1'b0;
            r_count <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= addr_nxt;
                    if (r_addr == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (r_step == LAST_STEP) begin
                        r_addr  <= h_rem;
                        r_pend  <= 1'b0;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    r_addr <= addr_nxt;
                    r_pend <= 1'b1;
                    if (e_stop) begin
                        r_count <= f_count;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_kind <= i_kind;
            r_key  <= i_key;
            r_val  <= i_value;
            r_sh   <= KPAD'(i_key);
            r_rem  <= '0;
            r_step <= '0;
        end
        if (r_state == S_HASH) begin
            r_sh       <= r_sh << 4;
            r_rem      <= h_rem;
            r_step     <= r_step + 1'b1;
            r_seen     <= '0;
            r_free_vld <= 1'b0;
        end
        if (r_state == S_PROBE) begin
            r_eval_idx <= r_addr;
            if (r_pend) begin
                r_seen     <= r_seen + 1'b1;
                r_free_vld <= e_free_vld;
                r_free     <= e_free;
            end
            if (e_stop) begin
                r_status <= f_status;
                r_fval   <= f_fval;
            end
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res_status = r_status;
    assign o_res_fval   = r_fval;
    assign o_res_count  = r_count;
endmodule
`default_nettype wire

// ===== sv/linear_probe_hash_table.sv =====
// Top level of the linear probe hash table: sequencer, slot store, result register.
//
//  channel | direction | handshake                 | words
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_kind, i_key, i_value
//  out     | output    | o_out_valid / i_out_ready | o_status, o_found_value, o_item_count
//
// The hash runs four key bits a cycle; the probe walk then reads one slot a cycle from the
// store's single read port and examines 1 to CAPACITY slots.
// After reset a clearing sweep marks every slot empty, with o_in_ready low.
// The result register holds one word; the next item is probed while it waits and
// its result is held back until the register frees.
`default_nettype none
`include "linear_probe_hash_table_defines.svh"
module linear_probe_hash_table #(
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire lpht_pkg::t_kind               i_kind,
    input  wire logic [KEY_BITS-1:0]           i_key,
    input  wire logic [VALUE_BITS-1:0]         i_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output lpht_pkg::t_status                  o_status,
    output logic      [lpht_pkg::FVAL_W-1:0]   o_found_value,
    output logic      [lpht_pkg::COUNT_W-1:0]  o_item_count
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_mem_ctl              mem_ctl;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [VALUE_BITS-1:0] wr_val;
    t_mark                 rd_mark;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic                  res_valid;
    logic                  res_ready;
    t_status               res_status;
    logic [VALUE_BITS-1:0] res_fval;
    logic [CNT_W-1:0]      res_count;
    logic [63:0]           fval_ext;
    logic [63:0]           count_ext;

    logic                  r_out_valid;
    t_status               r_status;
    logic [FVAL_W-1:0]     r_fval;
    logic [COUNT_W-1:0]    r_count;

    lpht_ctrl #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_mem_ctl    (mem_ctl),
        .o_rd_addr    (rd_addr),
        .o_wr_addr    (wr_addr),
        .o_wr_key     (wr_key),
        .o_wr_val     (wr_val),
        .i_rd_mark    (rd_mark),
        .i_rd_key     (rd_key),
        .i_rd_val     (rd_val),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res_status (res_status),
        .o_res_fval   (res_fval),
        .o_res_count  (res_count)
    );

    lpht_store #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_key  (wr_key),
        .i_wr_val  (wr_val),
        .o_rd_mark (rd_mark),
        .o_rd_key  (rd_key),
        .o_rd_val  (rd_val)
    );

    assign res_ready = !r_out_valid || i_out_ready;
    assign fval_ext  = 64'(res_fval);
    assign count_ext = 64'(res_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_status <= res_status;
            r_fval   <= fval_ext[FVAL_W-1:0];
            r_count  <= count_ext[COUNT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_value = r_fval;
    assign o_item_count  = r_count;

    `LPHT_ASSERT_NXT(a_accept_starts_work, i_clk, i_rst_n, i_in_valid && o_in_ready, !res_valid)
    `LPHT_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, res_valid && res_ready, o_out_valid)
    `LPHT_ASSERT_IMP(a_miss_no_value, i_clk, i_rst_n, o_out_valid && (o_status == ST_FULL || o_status == ST_MISSING), o_found_value == '0)
    `LPHT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, res_count <= CNT_W'(CAPACITY))
endmodule
`default_nettype wire

// ===== sim/linear_probe_hash_table_tb.sv =====
// Self-checking testbench for the linear probe hash table against a shadow table.
module tb;
    import lpht_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 80;
    localparam int ITEM_TARGET = 1600;

    localparam t_kind KIND_LOOKUP = 2'd2;
    localparam t_kind KIND_SPARE  = 2'd3;

    typedef struct packed {
        t_status     status;
        logic [31:0] fval;
        logic [6:0]  count;
    } table_answer_t;

    localparam table_answer_t NO_ANSWER = '0;

    typedef struct {
        t_kind         kind;
        logic [31:0]   key;
        logic [31:0]   value;
        bit            typed;
        table_answer_t answer;
    } directed_row_t;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    t_kind               in_kind   = KIND_INSERT;
    logic [31:0]         in_key    = '0;
    logic [31:0]         in_value  = '0;
    logic                out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    t_status             o_status;
    logic [FVAL_W-1:0]   o_found_value;
    logic [COUNT_W-1:0]  o_item_count;

    logic [31:0]   shadow_key [CAPACITY];
    logic [31:0]   shadow_val [CAPACITY];
    t_mark         shadow_mark [CAPACITY];
    int unsigned   shadow_live;

    table_answer_t expected_answers [$];
    table_answer_t head_answer;
    int            err_count    = 0;
    int            items_sent   = 0;
    int            snd_idle_pct = 15;
    int            rcv_idle_pct = 63;
    int            cycle_count  = 0;
    logic [25:0]   hi_pool [8];
    logic [5:0]    cluster_base = '0;

    directed_row_t plan [20] = '{
        '{KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_MISSING, 32'h0, 7'd0}},
        '{KIND_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_MISSING, 32'h0, 7'd0}},
        '{KIND_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0, 7'd1}},
        '{KIND_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_SAME, 32'h0, 7'd1}},
        '{KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{ST_OTHER, 32'h0, 7'd1}},
        '{KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'hFFFF_FFFF, 7'd2}},
        '{KIND_INSERT, 32'h0000_0040, 32'hA5A5_A5A5, 1'b0, NO_ANSWER},
        '{KIND_INSERT, 32'h0000_0080, 32'h5A5A_5A5A, 1'b0, NO_ANSWER},
        '{KIND_INSERT, 32'h0000_003F, 32'h0000_0001, 1'b0, NO_ANSWER},
        '{KIND_LOOKUP, 32'h0000_0080, 32'h0000_0000, 1'b0, NO_ANSWER},
        '{KIND_SPARE,  32'h0000_0040, 32'h1234_5678, 1'b0, NO_ANSWER},
        '{KIND_REMOVE, 32'h0000_0040, 32'h0000_0000, 1'b0, NO_ANSWER},
        '{KIND_LOOKUP, 32'h0000_0080, 32'h0000_0000, 1'b0, NO_ANSWER},
        '{KIND_LOOKUP, 32'h0000_0040, 32'h0000_0000, 1'b0, NO_ANSWER},
        '{KIND_INSERT, 32'h0000_00C0, 32'h0000_FFFF, 1'b0, NO_ANSWER},
        '{KIND_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_ANSWER},
        '{KIND_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_ANSWER},
        '{KIND_SPARE,  32'hFFFF_FFFF, 32'h5555_AAAA, 1'b0, NO_ANSWER},
        '{KIND_LOOKUP, 32'h0000_003F, 32'h0000_0000, 1'b0, NO_ANSWER},
        '{KIND_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, NO_ANSWER}
    };

    linear_probe_hash_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (in_kind),
        .i_key         (in_key),
        .i_value       (in_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_item_count  (o_item_count)
    );

    always #1 i_clk = ~i_clk;

    function automatic table_answer_t predict_table_op(input t_kind kind,
                                                       input logic [31:0] key,
                                                       input logic [31:0] value);
        table_answer_t ans;
        int idx;
        int hit;
        int spare;
        hit   = -1;
        spare = -1;
        idx   = int'(key % 32'(CAPACITY));
        for (int n = 0; n < CAPACITY; n++) begin
            if (shadow_mark[idx] == MARK_EMPTY) begin
                if (spare < 0) spare = idx;
                break;
            end
            if (shadow_mark[idx] == MARK_USED) begin
                if (shadow_key[idx] == key) begin
                    hit = idx;
                    break;
                end
            end else if (spare < 0) begin
                spare = idx;
            end
            idx = (idx + 1) % CAPACITY;
        end
        ans.status = ST_MISSING;
        ans.fval   = '0;
        if (kind == KIND_INSERT) begin
            if (hit >= 0) begin
                ans.fval   = shadow_val[hit];
                ans.status = (ans.fval == value) ? ST_SAME : ST_OTHER;
            end else if (spare < 0) begin
                ans.status = ST_FULL;
            end else begin
                shadow_key[spare]  = key;
                shadow_val[spare]  = value;
                shadow_mark[spare] = MARK_USED;
                shadow_live++;
                ans.status = ST_OK;
                ans.fval   = value;
            end
        end else if (kind == KIND_REMOVE) begin
            if (hit >= 0) begin
                ans.fval         = shadow_val[hit];
                shadow_mark[hit] = MARK_DELETED;
                if (shadow_live > 0) shadow_live--;
                ans.status = ST_OK;
            end
        end else if (hit >= 0) begin
            ans.fval   = shadow_val[hit];
            ans.status = ST_OK;
        end
        ans.count = 7'(shadow_live);
        return ans;
    endfunction

    function automatic bit pick_live(output logic [31:0] key, output logic [31:0] value);
        int used_slots [$];
        int s;
        key   = '0;
        value = '0;
        for (int j = 0; j < CAPACITY; j++) begin
            if (shadow_mark[j] == MARK_USED) used_slots.push_back(j);
        end
        if (used_slots.size() == 0) return 1'b0;
        s     = used_slots[$urandom_range(0, used_slots.size() - 1)];
        key   = shadow_key[s];
        value = shadow_val[s];
        return 1'b1;
    endfunction

    // clustered keys crowd a few home slots so that probes run long
    function automatic logic [31:0] fresh_key();
        logic [5:0] low;
        if ($urandom_range(0, 3) == 0) return $urandom;
        low = cluster_base + 6'($urandom_range(0, 5));
        return {hi_pool[$urandom_range(0, 7)], low};
    endfunction

    function automatic logic [31:0] random_value();
        if ($urandom_range(0, 1) == 1) return $urandom;
        return 32'($urandom_range(0, 3));
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    task automatic send_item(input t_kind kind, input logic [31:0] key,
                             input logic [31:0] value, input bit typed,
                             input table_answer_t typed_ans, output table_answer_t ans);
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        in_valid <= 1'b1;
        in_kind  <= kind;
        in_key   <= key;
        in_value <= value;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        ans = predict_table_op(kind, key, value);
        expected_answers.push_back(typed ? typed_ans : ans);
        items_sent++;
        if (items_sent < 540) begin
            snd_idle_pct = 15;
            rcv_idle_pct = 63;
        end else if (items_sent < 1080) begin
            snd_idle_pct = 63;
            rcv_idle_pct = 15;
        end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
        end
    endtask

    task automatic hold_until_answered();
        in_valid <= 1'b0;
        while (expected_answers.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_answers.size() == 0) begin
                report_mismatch($sformatf("unexpected word, status %0d", o_status));
            end else begin
                head_answer = expected_answers.pop_front();
                if (o_status !== head_answer.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_status, head_answer.status));
                if (o_found_value !== head_answer.fval)
                    report_mismatch($sformatf("found_value %h, want %h",
                                              o_found_value, head_answer.fval));
                if (o_item_count !== head_answer.count)
                    report_mismatch($sformatf("item_count %0d, want %0d",
                                              o_item_count, head_answer.count));
            end
        end
        out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("linear_probe_hash_table verification failed");
            $finish;
        end
    end

    initial begin
        int            r;
        int            n;
        int            fulls;
        int            mode;
        logic [31:0]   k;
        logic [31:0]   v;
        logic [31:0]   live_k;
        logic [31:0]   live_v;
        bit            have_live;
        t_kind         kind_sel;
        table_answer_t ans;

        foreach (shadow_mark[s]) shadow_mark[s] = MARK_EMPTY;
        shadow_live = 0;
        hi_pool[0]  = '0;
        hi_pool[1]  = '1;
        for (int j = 2; j < 8; j++) hi_pool[j] = 26'($urandom);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[j])
            send_item(plan[j].kind, plan[j].key, plan[j].value, plan[j].typed,
                      plan[j].answer, ans);
        hold_until_answered();

        // fill and drain leave no empty slot behind, so they come late
        while (items_sent < ITEM_TARGET) begin
            mode         = $urandom_range(0, 9);
            cluster_base = 6'($urandom);
            if (mode == 9) begin
                hold_until_answered();
            end else if (items_sent >= 800 && mode == 7) begin
                fulls = 0;
                n     = 0;
                while (fulls < 2 && n < 120) begin
                    k = ($urandom_range(0, 1) == 1) ? 32'($urandom) : fresh_key();
                    send_item(KIND_INSERT, k, random_value(), 1'b0, NO_ANSWER, ans);
                    if (ans.status == ST_FULL) fulls++;
                    n++;
                end
                repeat (3) send_item(KIND_LOOKUP, fresh_key(), random_value(), 1'b0,
                                     NO_ANSWER, ans);
                send_item(KIND_SPARE, fresh_key(), random_value(), 1'b0, NO_ANSWER, ans);
            end else if (items_sent >= 800 && mode == 8) begin
                n = 0;
                while (shadow_live != 0 && n < 80) begin
                    have_live = pick_live(live_k, live_v);
                    if ($urandom_range(0, 4) == 0)
                        send_item(KIND_LOOKUP, fresh_key(), random_value(), 1'b0,
                                  NO_ANSWER, ans);
                    else
                        send_item(KIND_REMOVE, live_k, random_value(), 1'b0,
                                  NO_ANSWER, ans);
                    n++;
                end
                repeat (10) send_item(KIND_INSERT, fresh_key(), random_value(), 1'b0,
                                      NO_ANSWER, ans);
            end else begin
                repeat (40) begin
                    have_live = pick_live(live_k, live_v);
                    k         = fresh_key();
                    v         = random_value();
                    kind_sel  = KIND_LOOKUP;
                    r         = $urandom_range(0, 99);
                    if (r < 40) begin
                        kind_sel = KIND_INSERT;
                    end else if (r < 50) begin
                        kind_sel = KIND_INSERT;
                        if (have_live) begin
                            k = live_k;
                            if ($urandom_range(0, 1) == 1) v = live_v;
                        end
                    end else if (r < 72) begin
                        kind_sel = KIND_REMOVE;
                        if (have_live && r < 65) k = live_k;
                    end else if (r < 95) begin
                        if (have_live && r < 87) k = live_k;
                    end else begin
                        kind_sel = KIND_SPARE;
                        if (have_live && $urandom_range(0, 1) == 1) k = live_k;
                    end
                    send_item(kind_sel, k, v, 1'b0, NO_ANSWER, ans);
                end
            end
        end

        hold_until_answered();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("linear_probe_hash_table verification clean");
        end else begin
            $display("linear_probe_hash_table verification failed");
        end
        $finish;
    end
endmodule

// ===== linear_probe_hash_table.f =====
+incdir+sv
sv/lpht_pkg.sv
sv/lpht_store.sv
sv/lpht_ctrl.sv
sv/linear_probe_hash_table.sv
sim/linear_probe_hash_table_tb.sv
